@@ src/rqnp_pkg.sv @@
// ----------------------------------------------------------------------------
// rqnp_pkg
// Shared types, constants, micro-program and edge classification for the
// ray against quad nearest-hit picker.
// ----------------------------------------------------------------------------
package rqnp_pkg;

    // Datapath word: wide enough for 10^6 * (n.d)^2 and every other product.
    localparam int DP_W        = 224;
    localparam int RF_DEPTH    = 32;
    localparam int RA_W        = 5;
    localparam int DIGIT_W     = 8;
    localparam int Q_BITS      = 31;
    localparam int QCNT_W      = 5;
    localparam int PC_W        = 7;
    localparam int MAX_FACES_DEF = 1024;
    localparam int CFG_IDX_W   = 3;

    // Micro-op codes.
    localparam logic [3:0] OP_LDIN  = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MOV   = 4'd3;
    localparam logic [3:0] OP_NEGIF = 4'd4;
    localparam logic [3:0] OP_MUL   = 4'd5;
    localparam logic [3:0] OP_DIV   = 4'd6;
    localparam logic [3:0] OP_KEEP  = 4'd7;

    // Branch codes.
    localparam logic [1:0] BR_NONE = 2'd0;
    localparam logic [1:0] BR_NEG  = 2'd1;
    localparam logic [1:0] BR_ZERO = 2'd2;
    localparam logic [1:0] BR_END  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    // Register file slots. The first sixteen are loaded by OP_LDIN.
    localparam logic [RA_W-1:0] R_E1X  = 5'd0;
    localparam logic [RA_W-1:0] R_E1Y  = 5'd1;
    localparam logic [RA_W-1:0] R_E1Z  = 5'd2;
    localparam logic [RA_W-1:0] R_E2X  = 5'd3;
    localparam logic [RA_W-1:0] R_E2Y  = 5'd4;
    localparam logic [RA_W-1:0] R_E2Z  = 5'd5;
    localparam logic [RA_W-1:0] R_WX   = 5'd6;
    localparam logic [RA_W-1:0] R_WY   = 5'd7;
    localparam logic [RA_W-1:0] R_WZ   = 5'd8;
    localparam logic [RA_W-1:0] R_DX   = 5'd9;
    localparam logic [RA_W-1:0] R_DY   = 5'd10;
    localparam logic [RA_W-1:0] R_DZ   = 5'd11;
    localparam logic [RA_W-1:0] R_K1E6 = 5'd12;
    localparam logic [RA_W-1:0] R_K100 = 5'd13;
    localparam logic [RA_W-1:0] R_K64K = 5'd14;
    localparam logic [RA_W-1:0] R_K2P32 = 5'd15;
    localparam logic [RA_W-1:0] R_NX   = 5'd16;
    localparam logic [RA_W-1:0] R_NY   = 5'd17;
    localparam logic [RA_W-1:0] R_NZ   = 5'd18;
    localparam logic [RA_W-1:0] R_DN   = 5'd19;
    localparam logic [RA_W-1:0] R_NW   = 5'd20;
    localparam logic [RA_W-1:0] R_NN   = 5'd21;
    localparam logic [RA_W-1:0] R_T0   = 5'd22;
    localparam logic [RA_W-1:0] R_T1   = 5'd23;
    localparam logic [RA_W-1:0] R_T2   = 5'd24;
    localparam logic [RA_W-1:0] R_S    = 5'd25;
    localparam logic [RA_W-1:0] R_LIM  = 5'd26;

    // Quotient destinations of OP_DIV.
    localparam logic [RA_W-1:0] Q_U = 5'd0;
    localparam logic [RA_W-1:0] Q_V = 5'd1;
    localparam logic [RA_W-1:0] Q_T = 5'd2;

    localparam int LDIN_COUNT = 16;
    localparam int PC_SIDE    = 49;
    localparam int SIDE_LEN   = 22;
    localparam int PC_TAIL    = PC_SIDE + 2 * SIDE_LEN;

    typedef struct packed {
        logic [3:0]      op;
        logic [RA_W-1:0] dst;
        logic [RA_W-1:0] a;
        logic [RA_W-1:0] b;
        logic [1:0]      br;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic go;
        logic emit;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } sts_t;

    function automatic uop_t mk(input logic [3:0] op, input logic [RA_W-1:0] dst,
                                input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                                input logic [1:0] br);
        uop_t u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.br  = br;
        return u;
    endfunction

    // Micro-program: plane normal, parallel and distance tests, the two side
    // tests with their normalized coordinates, the distance, then the keep.
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] k;
        logic            sel_v;
        logic [RA_W-1:0] ex;
        logic [RA_W-1:0] ey;
        logic [RA_W-1:0] ez;
        logic [RA_W-1:0] qd;
        uop_t            u;
        k     = '0;
        sel_v = 1'b0;
        u     = mk(OP_KEEP, R_T0, R_T0, R_T0, BR_END);
        if (pc < PC_W'(LDIN_COUNT)) begin
            u = mk(OP_LDIN, pc[RA_W-1:0], pc[RA_W-1:0], pc[RA_W-1:0], BR_NONE);
        end
        else if (pc >= PC_W'(PC_SIDE) && pc < PC_W'(PC_TAIL)) begin
            k = pc - PC_W'(PC_SIDE);
            sel_v = (k >= PC_W'(SIDE_LEN));
            if (sel_v) begin
                k = k - PC_W'(SIDE_LEN);
            end
            ex = sel_v ? R_E2X : R_E1X;
            ey = sel_v ? R_E2Y : R_E1Y;
            ez = sel_v ? R_E2Z : R_E1Z;
            qd = sel_v ? Q_V : Q_U;
            unique case (k)
                7'd0:    u = mk(OP_MUL, R_T1, R_DX, ex, BR_NONE);
                7'd1:    u = mk(OP_MUL, R_T0, R_DY, ey, BR_NONE);
                7'd2:    u = mk(OP_ADD, R_T1, R_T1, R_T0, BR_NONE);
                7'd3:    u = mk(OP_MUL, R_T0, R_DZ, ez, BR_NONE);
                7'd4:    u = mk(OP_ADD, R_T1, R_T1, R_T0, BR_NONE);
                7'd5:    u = mk(OP_MUL, R_T2, R_WX, ex, BR_NONE);
                7'd6:    u = mk(OP_MUL, R_T0, R_WY, ey, BR_NONE);
                7'd7:    u = mk(OP_ADD, R_T2, R_T2, R_T0, BR_NONE);
                7'd8:    u = mk(OP_MUL, R_T0, R_WZ, ez, BR_NONE);
                7'd9:    u = mk(OP_ADD, R_T2, R_T2, R_T0, BR_NONE);
                7'd10:   u = mk(OP_MUL, R_S, R_NW, R_T1, BR_NONE);
                7'd11:   u = mk(OP_MUL, R_T0, R_DN, R_T2, BR_NONE);
                7'd12:   u = mk(OP_SUB, R_S, R_S, R_T0, BR_NEG);
                7'd13:   u = mk(OP_MUL, R_T1, ex, ex, BR_NONE);
                7'd14:   u = mk(OP_MUL, R_T0, ey, ey, BR_NONE);
                7'd15:   u = mk(OP_ADD, R_T1, R_T1, R_T0, BR_NONE);
                7'd16:   u = mk(OP_MUL, R_T0, ez, ez, BR_NONE);
                7'd17:   u = mk(OP_ADD, R_T1, R_T1, R_T0, BR_NONE);
                7'd18:   u = mk(OP_MUL, R_LIM, R_DN, R_T1, BR_NONE);
                7'd19:   u = mk(OP_SUB, R_T0, R_LIM, R_S, BR_NEG);
                7'd20:   u = mk(OP_MUL, R_S, R_S, R_K64K, BR_NONE);
                7'd21:   u = mk(OP_DIV, qd, R_S, R_LIM, BR_NONE);
                default: u = mk(OP_KEEP, R_T0, R_T0, R_T0, BR_END);
            endcase
        end
        else begin
            unique case (pc)
                7'd16:   u = mk(OP_MUL, R_NX, R_E1Y, R_E2Z, BR_NONE);
                7'd17:   u = mk(OP_MUL, R_T0, R_E1Z, R_E2Y, BR_NONE);
                7'd18:   u = mk(OP_SUB, R_NX, R_NX, R_T0, BR_NONE);
                7'd19:   u = mk(OP_MUL, R_NY, R_E1Z, R_E2X, BR_NONE);
                7'd20:   u = mk(OP_MUL, R_T0, R_E1X, R_E2Z, BR_NONE);
                7'd21:   u = mk(OP_SUB, R_NY, R_NY, R_T0, BR_NONE);
                7'd22:   u = mk(OP_MUL, R_NZ, R_E1X, R_E2Y, BR_NONE);
                7'd23:   u = mk(OP_MUL, R_T0, R_E1Y, R_E2X, BR_NONE);
                7'd24:   u = mk(OP_SUB, R_NZ, R_NZ, R_T0, BR_NONE);
                7'd25:   u = mk(OP_MUL, R_DN, R_NX, R_DX, BR_NONE);
                7'd26:   u = mk(OP_MUL, R_T0, R_NY, R_DY, BR_NONE);
                7'd27:   u = mk(OP_ADD, R_DN, R_DN, R_T0, BR_NONE);
                7'd28:   u = mk(OP_MUL, R_T0, R_NZ, R_DZ, BR_NONE);
                7'd29:   u = mk(OP_ADD, R_DN, R_DN, R_T0, BR_ZERO);
                7'd30:   u = mk(OP_MUL, R_NW, R_NX, R_WX, BR_NONE);
                7'd31:   u = mk(OP_MUL, R_T0, R_NY, R_WY, BR_NONE);
                7'd32:   u = mk(OP_ADD, R_NW, R_NW, R_T0, BR_NONE);
                7'd33:   u = mk(OP_MUL, R_T0, R_NZ, R_WZ, BR_NONE);
                7'd34:   u = mk(OP_ADD, R_NW, R_NW, R_T0, BR_NONE);
                7'd35:   u = mk(OP_MUL, R_NN, R_NX, R_NX, BR_NONE);
                7'd36:   u = mk(OP_MUL, R_T0, R_NY, R_NY, BR_NONE);
                7'd37:   u = mk(OP_ADD, R_NN, R_NN, R_T0, BR_NONE);
                7'd38:   u = mk(OP_MUL, R_T0, R_NZ, R_NZ, BR_NONE);
                7'd39:   u = mk(OP_ADD, R_NN, R_NN, R_T0, BR_NONE);
                7'd40:   u = mk(OP_MUL, R_T0, R_DN, R_DN, BR_NONE);
                7'd41:   u = mk(OP_MUL, R_T0, R_T0, R_K1E6, BR_NONE);
                7'd42:   u = mk(OP_MUL, R_T1, R_NN, R_K2P32, BR_NONE);
                7'd43:   u = mk(OP_SUB, R_T0, R_T0, R_T1, BR_NEG);
                7'd44:   u = mk(OP_MOV, R_T1, R_DN, R_DN, BR_NONE);
                7'd45:   u = mk(OP_NEGIF, R_DN, R_DN, R_DN, BR_NONE);
                7'd46:   u = mk(OP_NEGIF, R_NW, R_NW, R_NW, BR_NONE);
                7'd47:   u = mk(OP_MUL, R_T0, R_NW, R_K100, BR_NONE);
                7'd48:   u = mk(OP_SUB, R_T0, R_T0, R_DN, BR_NEG);
                7'd93:   u = mk(OP_MUL, R_T0, R_NW, R_K64K, BR_NONE);
                7'd94:   u = mk(OP_DIV, Q_T, R_T0, R_DN, BR_NONE);
                default: u = mk(OP_KEEP, R_T0, R_T0, R_T0, BR_END);
            endcase
        end
        return u;
    endfunction

    // Nearest edge from the diagonal split of the unit square.
    function automatic logic [1:0] edge_of(input logic [16:0] u, input logic [16:0] v);
        logic [17:0] one_m_u;
        logic [17:0] one_m_v;
        logic [1:0]  e;
        one_m_u = 18'd65536 - {1'b0, u};
        one_m_v = 18'd65536 - {1'b0, v};
        if (u < 17'd32768) begin
            if (v < u)                      e = 2'd0;
            else if (v < 17'd32768)         e = 2'd3;
            else if ({1'b0, u} < one_m_v)   e = 2'd3;
            else                            e = 2'd2;
        end
        else begin
            if ({1'b0, v} < one_m_u)        e = 2'd0;
            else if (v < 17'd32768)         e = 2'd1;
            else if (v < u)                 e = 2'd1;
            else                            e = 2'd2;
        end
        return e;
    endfunction

endpackage

@@ src/ray_quad_nearest_pick.sv @@
// ----------------------------------------------------------------------------
// ray_quad_nearest_pick
// Nearest hit of one configured ray against a stream of quad faces, exact
// fixed-point tests, one result per set of faces.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  face      start / busy              corner_a/b/c_x/y/z, face_index, last_face
//  result    done (one-cycle strobe)   hit, hit_face, hit_distance, hit_u,
//                                      hit_v, nearest_edge
//  config    cfg_we                    cfg_index, cfg_data
//
//  A face is taken when start is high and busy is low. A tested face walks a
//  96-step micro-program on one register file; a multiply iterates over the
//  bytes of its second operand's magnitude and a division over its 31
//  quotient bits; a rejected face stops early. A face past the per-set limit
//  is not tested. The result beat is registered from the emit state that
//  follows the last face and cannot be held off. Reset clears the ray to a
//  +z direction at the origin and empties the set.
// ----------------------------------------------------------------------------
module ray_quad_nearest_pick #(
    parameter int MAX_FACES = rqnp_pkg::MAX_FACES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rqnp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             corner_a_x,
    input  logic signed [31:0]             corner_a_y,
    input  logic signed [31:0]             corner_a_z,
    input  logic signed [31:0]             corner_b_x,
    input  logic signed [31:0]             corner_b_y,
    input  logic signed [31:0]             corner_b_z,
    input  logic signed [31:0]             corner_c_x,
    input  logic signed [31:0]             corner_c_y,
    input  logic signed [31:0]             corner_c_z,
    input  logic [9:0]                     face_index,
    input  logic                           last_face,
    output logic                           done,
    output logic                           hit,
    output logic [9:0]                     hit_face,
    output logic [30:0]                    hit_distance,
    output logic [16:0]                    hit_u,
    output logic [16:0]                    hit_v,
    output logic [1:0]                     nearest_edge
);
    import rqnp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rqnp_ctrl #(
        .MAX_FACES (MAX_FACES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_face (last_face),
        .busy      (busy),
        .cmd       (cmd),
        .sts       (sts)
    );

    rqnp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .corner_a_x   (corner_a_x),
        .corner_a_y   (corner_a_y),
        .corner_a_z   (corner_a_z),
        .corner_b_x   (corner_b_x),
        .corner_b_y   (corner_b_y),
        .corner_b_z   (corner_b_z),
        .corner_c_x   (corner_c_x),
        .corner_c_y   (corner_c_y),
        .corner_c_z   (corner_c_z),
        .face_index   (face_index),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .hit          (hit),
        .hit_face     (hit_face),
        .hit_distance (hit_distance),
        .hit_u        (hit_u),
        .hit_v        (hit_v),
        .nearest_edge (nearest_edge)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted more than one cycle");

    a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done)
        else $error("result request did not produce a beat");

    a_op_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done || cmd.go) |-> busy)
        else $error("datapath op active while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_face) |=> busy)
        else $error("accepted last face did not make the block busy");

endmodule

@@ src/rqnp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqnp_ctrl
// Sequencer: accepts faces, counts them per set, steps the micro-program and
// requests the result when the last face of a set is done.
// ----------------------------------------------------------------------------
module rqnp_ctrl #(
    parameter int MAX_FACES = rqnp_pkg::MAX_FACES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last_face,
    output logic           busy,
    output rqnp_pkg::cmd_t cmd,
    input  rqnp_pkg::sts_t sts
);
    import rqnp_pkg::*;

    localparam int CNT_W = $clog2(MAX_FACES + 1);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ISSUE = 2'd1;
    localparam logic [1:0] C_WAIT  = 2'd2;
    localparam logic [1:0] C_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             last_reg, last_next;
    uop_t             uop;
    logic             stop;

    assign uop  = uop_at(pc_reg);
    assign busy = (state_reg != C_IDLE);

    assign stop = (uop.br == BR_END) || (uop.br == BR_NEG && sts.neg) ||
                  (uop.br == BR_ZERO && sts.zero);

    always_comb begin
        cmd.capture = start && (state_reg == C_IDLE);
        cmd.go      = (state_reg == C_ISSUE);
        cmd.emit    = (state_reg == C_EMIT);
        cmd.uop     = uop;
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        count_next = count_reg;
        last_next  = last_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    last_next = last_face;
                    if (count_reg < CNT_W'(MAX_FACES)) begin
                        count_next = count_reg + 1'b1;
                        pc_next    = '0;
                        state_next = C_ISSUE;
                    end
                    else if (last_face) begin
                        state_next = C_EMIT;
                    end
                end
            end
            C_ISSUE: begin
                state_next = C_WAIT;
            end
            C_WAIT: begin
                if (sts.done) begin
                    if (stop) begin
                        state_next = last_reg ? C_EMIT : C_IDLE;
                    end
                    else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = C_ISSUE;
                    end
                end
            end
            C_EMIT: begin
                count_next = '0;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            pc_reg    <= '0;
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ src/rqnp_dp.sv @@
// ----------------------------------------------------------------------------
// rqnp_dp
// Datapath: ray registers, face capture, a 32-entry wide register file, a
// byte-serial multiplier, a restoring divider, the nearest-hit keeper and the
// result registers.
// ----------------------------------------------------------------------------
module rqnp_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rqnp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic signed [31:0]                 corner_a_x,
    input  logic signed [31:0]                 corner_a_y,
    input  logic signed [31:0]                 corner_a_z,
    input  logic signed [31:0]                 corner_b_x,
    input  logic signed [31:0]                 corner_b_y,
    input  logic signed [31:0]                 corner_b_z,
    input  logic signed [31:0]                 corner_c_x,
    input  logic signed [31:0]                 corner_c_y,
    input  logic signed [31:0]                 corner_c_z,
    input  logic [9:0]                         face_index,
    input  rqnp_pkg::cmd_t                     cmd,
    output rqnp_pkg::sts_t                     sts,
    output logic                               done,
    output logic                               hit,
    output logic [9:0]                         hit_face,
    output logic [30:0]                        hit_distance,
    output logic [16:0]                        hit_u,
    output logic [16:0]                        hit_v,
    output logic [1:0]                         nearest_edge
);
    import rqnp_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_EXEC = 3'd1;
    localparam logic [2:0] D_MUL  = 3'd2;
    localparam logic [2:0] D_DIV  = 3'd3;

    // Ray registers.
    logic [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [31:0] dir_x_reg, dir_y_reg, dir_z_reg;

    // Face capture: edges and origin offset, 33 bits signed each.
    logic [32:0] e1x_reg, e1y_reg, e1z_reg;
    logic [32:0] e2x_reg, e2y_reg, e2z_reg;
    logic [32:0] wx_reg, wy_reg, wz_reg;
    logic [9:0]  face_reg;

    logic [2:0]      state_reg;
    logic [3:0]      op_reg;
    logic [RA_W-1:0] dst_reg;
    logic [RA_W-1:0] src_reg;
    logic [DP_W-1:0] rd_a_reg, rd_b_reg;
    logic            neg_flag_reg;

    logic [DP_W-1:0] rf_mem [RF_DEPTH];

    logic [DP_W-1:0]   ma_reg, mb_reg, acc_reg;
    logic signed [DP_W+DIGIT_W:0] prod_full;

    logic [DP_W-1:0]   rem_reg, dsh_reg;
    logic [Q_BITS-1:0] q_reg;
    logic [QCNT_W-1:0] qcnt_reg;
    logic [DP_W-1:0]   diff;
    logic [Q_BITS-1:0] q_next;

    logic [Q_BITS-1:0] cur_t_reg;
    logic [16:0]       cur_u_reg, cur_v_reg;

    logic              found_reg;
    logic [Q_BITS-1:0] best_t_reg;
    logic [9:0]        best_face_reg;
    logic [16:0]       best_u_reg, best_v_reg;

    logic [DP_W-1:0] src_val;
    logic [DP_W-1:0] alu_res;
    logic            alu_wr;
    logic            wr_en;
    logic [DP_W-1:0] wr_data;
    logic            mul_end;
    logic            div_end;

    function automatic logic [DP_W-1:0] sx33(input logic [32:0] x);
        return {{(DP_W-33){x[32]}}, x};
    endfunction

    function automatic logic [32:0] sub33(input logic [31:0] p, input logic [31:0] q);
        return {p[31], p} - {q[31], q};
    endfunction

    // Sources of OP_LDIN.
    always_comb begin
        unique case (src_reg)
            R_E1X:   src_val = sx33(e1x_reg);
            R_E1Y:   src_val = sx33(e1y_reg);
            R_E1Z:   src_val = sx33(e1z_reg);
            R_E2X:   src_val = sx33(e2x_reg);
            R_E2Y:   src_val = sx33(e2y_reg);
            R_E2Z:   src_val = sx33(e2z_reg);
            R_WX:    src_val = sx33(wx_reg);
            R_WY:    src_val = sx33(wy_reg);
            R_WZ:    src_val = sx33(wz_reg);
            R_DX:    src_val = sx33({dir_x_reg[31], dir_x_reg});
            R_DY:    src_val = sx33({dir_y_reg[31], dir_y_reg});
            R_DZ:    src_val = sx33({dir_z_reg[31], dir_z_reg});
            R_K1E6:  src_val = DP_W'(1000000);
            R_K100:  src_val = DP_W'(100);
            R_K64K:  src_val = DP_W'(65536);
            R_K2P32: src_val = DP_W'(64'h1_0000_0000);
            default: src_val = '0;
        endcase
    end

    always_comb begin
        alu_wr  = 1'b0;
        alu_res = rd_a_reg;
        unique case (op_reg) inside
            OP_LDIN: begin
                alu_wr  = 1'b1;
                alu_res = src_val;
            end
            OP_ADD: begin
                alu_wr  = 1'b1;
                alu_res = rd_a_reg + rd_b_reg;
            end
            OP_SUB: begin
                alu_wr  = 1'b1;
                alu_res = rd_a_reg - rd_b_reg;
            end
            OP_MOV: begin
                alu_wr  = 1'b1;
                alu_res = rd_a_reg;
            end
            OP_NEGIF: begin
                alu_wr  = 1'b1;
                alu_res = neg_flag_reg ? (~rd_a_reg + 1'b1) : rd_a_reg;
            end
            OP_MUL, OP_DIV, OP_KEEP: begin
                alu_wr = 1'b0;
            end
            default: alu_wr = 1'b0;
        endcase
    end

    assign prod_full = $signed(ma_reg) * $signed({1'b0, mb_reg[DIGIT_W-1:0]});
    assign mul_end   = (state_reg == D_MUL) && (mb_reg == '0);

    assign diff    = rem_reg - dsh_reg;
    assign q_next  = {q_reg[Q_BITS-2:0], ~diff[DP_W-1]};
    assign div_end = (state_reg == D_DIV) && (qcnt_reg == QCNT_W'(1));

    assign wr_en   = ((state_reg == D_EXEC) && alu_wr) || mul_end;
    assign wr_data = mul_end ? acc_reg : alu_res;

    // Flags are forwarded from the value being written so that the sequencer
    // can branch in the same cycle the op completes.
    always_comb begin
        sts.done = ((state_reg == D_EXEC) && (op_reg != OP_MUL) && (op_reg != OP_DIV))
                   || mul_end || div_end;
        sts.neg  = wr_data[DP_W-1];
        sts.zero = (wr_data == '0);
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            rf_mem[dst_reg] <= wr_data;
        end
        if (cmd.go) begin
            rd_a_reg <= rf_mem[cmd.uop.a];
            rd_b_reg <= rf_mem[cmd.uop.b];
        end
    end

    // Face capture and arithmetic working registers.
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            e1x_reg  <= sub33(corner_b_x, corner_a_x);
            e1y_reg  <= sub33(corner_b_y, corner_a_y);
            e1z_reg  <= sub33(corner_b_z, corner_a_z);
            e2x_reg  <= sub33(corner_c_x, corner_a_x);
            e2y_reg  <= sub33(corner_c_y, corner_a_y);
            e2z_reg  <= sub33(corner_c_z, corner_a_z);
            wx_reg   <= sub33(corner_a_x, org_x_reg);
            wy_reg   <= sub33(corner_a_y, org_y_reg);
            wz_reg   <= sub33(corner_a_z, org_z_reg);
            face_reg <= face_index;
        end
        if (cmd.go) begin
            op_reg  <= cmd.uop.op;
            dst_reg <= cmd.uop.dst;
            src_reg <= cmd.uop.a;
        end
        if (state_reg == D_EXEC) begin
            // Multiplier runs on |b| so the loop ends once its bytes run out.
            ma_reg   <= rd_b_reg[DP_W-1] ? (~rd_a_reg + 1'b1) : rd_a_reg;
            mb_reg   <= rd_b_reg[DP_W-1] ? (~rd_b_reg + 1'b1) : rd_b_reg;
            acc_reg  <= '0;
            rem_reg  <= rd_a_reg;
            dsh_reg  <= rd_b_reg << (Q_BITS - 1);
            q_reg    <= '0;
        end
        else if (state_reg == D_MUL) begin
            acc_reg <= acc_reg + prod_full[DP_W-1:0];
            ma_reg  <= ma_reg << DIGIT_W;
            mb_reg  <= mb_reg >> DIGIT_W;
        end
        else if (state_reg == D_DIV) begin
            if (!diff[DP_W-1]) begin
                rem_reg <= diff;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= q_next;
        end
        if (div_end) begin
            unique case (dst_reg)
                Q_U:     cur_u_reg <= q_next[16:0];
                Q_V:     cur_v_reg <= q_next[16:0];
                default: cur_t_reg <= q_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= D_IDLE;
            qcnt_reg     <= '0;
            neg_flag_reg <= 1'b0;
        end
        else begin
            if (wr_en && !((state_reg == D_EXEC) && (op_reg == OP_NEGIF))) begin
                neg_flag_reg <= wr_data[DP_W-1];
            end
            unique case (state_reg)
                D_IDLE: begin
                    if (cmd.go) begin
                        state_reg <= D_EXEC;
                    end
                end
                D_EXEC: begin
                    if (op_reg == OP_MUL) begin
                        state_reg <= D_MUL;
                    end
                    else if (op_reg == OP_DIV) begin
                        qcnt_reg  <= QCNT_W'(Q_BITS);
                        state_reg <= D_DIV;
                    end
                    else begin
                        state_reg <= D_IDLE;
                    end
                end
                D_MUL: begin
                    if (mul_end) begin
                        state_reg <= D_IDLE;
                    end
                end
                D_DIV: begin
                    qcnt_reg <= qcnt_reg - 1'b1;
                    if (div_end) begin
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // Ray registers, nearest-hit keeper and result beat.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
            dir_x_reg     <= '0;
            dir_y_reg     <= '0;
            dir_z_reg     <= 32'd65536;
            found_reg     <= 1'b0;
            best_t_reg    <= '0;
            best_face_reg <= '0;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            done          <= 1'b0;
            hit           <= 1'b0;
            hit_face      <= '0;
            hit_distance  <= '0;
            hit_u         <= '0;
            hit_v         <= '0;
            nearest_edge  <= '0;
        end
        else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: org_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                    CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                    CFG_DIR_X:    dir_x_reg <= cfg_data;
                    CFG_DIR_Y:    dir_y_reg <= cfg_data;
                    CFG_DIR_Z:    dir_z_reg <= cfg_data;
                    default:      ;
                endcase
            end
            done <= cmd.emit;
            if (cmd.emit) begin
                hit          <= found_reg;
                hit_face     <= found_reg ? best_face_reg : '0;
                hit_distance <= found_reg ? best_t_reg : '0;
                hit_u        <= found_reg ? best_u_reg : '0;
                hit_v        <= found_reg ? best_v_reg : '0;
                nearest_edge <= found_reg ? edge_of(best_u_reg, best_v_reg) : 2'd0;
                found_reg     <= 1'b0;
                best_t_reg    <= '0;
                best_face_reg <= '0;
                best_u_reg    <= '0;
                best_v_reg    <= '0;
            end
            else if ((state_reg == D_EXEC) && (op_reg == OP_KEEP)) begin
                if (!found_reg || (cur_t_reg < best_t_reg)) begin
                    found_reg     <= 1'b1;
                    best_t_reg    <= cur_t_reg;
                    best_face_reg <= face_reg;
                    best_u_reg    <= cur_u_reg;
                    best_v_reg    <= cur_v_reg;
                end
            end
        end
    end

endmodule
